// ===== design/rpis_pkg.sv =====
package rpis_pkg;

  localparam int SampleBits = 16;
  localparam int CoordBits  = 32;
  localparam int RadiusBits = 31;
  localparam int CfgIdxBits = 8;
  localparam int CfgDataBits = 32;

  // register indexes
  localparam logic [CfgIdxBits-1:0] CfgRadius  = 8'd0;
  localparam logic [CfgIdxBits-1:0] CfgCenterX = 8'd1;
  localparam logic [CfgIdxBits-1:0] CfgCenterY = 8'd2;
  localparam logic [CfgIdxBits-1:0] CfgCenterZ = 8'd3;

  localparam logic [RadiusBits-1:0] RadiusReset = 31'd65536;

  // one root digit per stage
  localparam int RootSteps = 16;
  // accept edge to strobe edge
  localparam int Latency = RootSteps + 11;

  // taylor coefficients of sin(pi/2 * x), q2.30 magnitudes
  localparam logic [30:0] K1 = 31'd1686629713;
  localparam logic [30:0] K3 = 31'd693598668;
  localparam logic [30:0] K5 = 31'd85569306;
  localparam logic [30:0] K7 = 31'd5026995;
  localparam logic [30:0] K9 = 31'd172272;

  typedef struct packed {
    logic signed [SampleBits-1:0] polar_sample;
    logic [SampleBits-1:0]        azimuth_sample;
    logic [SampleBits-1:0]        radial_sample;
  } req_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] point_z;
  } res_t;

endpackage

// ===== design/random_point_in_sphere.sv =====
// uniform random point inside a sphere
//
// a request carries three uniform samples: polar (q1.15 cosine of the polar
// angle), azimuth (fraction of a full turn) and radial (q0.16). it is taken
// at a rising edge with start_i high; busy_o is always low, so a new request
// can enter every cycle and one point leaves every cycle
// each point appears on res_o for one cycle with done_o high, in request
// order, after the capture stage, the square and cube roots (one result bit
// per stage, 16 stages) and ten stages for the sine polynomial, the scaling
// multiplies and the saturating add
// the receiver cannot stall; results are never held back
// configuration: cfg_we_i, cfg_idx_i and cfg_wdata_i write radius (unsigned q15.16,
// index 0) and center x/y/z (q16.16, indexes 1..3); other indexes are ignored.
// write only while no request is in flight
// reset clears the pipeline valid bits and loads radius 1.0 and center 0
module random_point_in_sphere (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  rpis_pkg::req_t                  req_i,
  input  logic                            cfg_we_i,
  input  logic [rpis_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [rpis_pkg::CfgDataBits-1:0] cfg_wdata_i,
  output logic                            done_o,
  output rpis_pkg::res_t                  res_o
);
  import rpis_pkg::*;

  // configuration registers
  logic [RadiusBits-1:0]       radius_q;
  logic signed [CoordBits-1:0] center_x_q, center_y_q, center_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RadiusReset;
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRadius:  radius_q   <= cfg_wdata_i[RadiusBits-1:0];
        CfgCenterX: center_x_q <= cfg_wdata_i[CoordBits-1:0];
        CfgCenterY: center_y_q <= cfg_wdata_i[CoordBits-1:0];
        CfgCenterZ: center_z_q <= cfg_wdata_i[CoordBits-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // root pipeline: stage 0 captures the request, stages 1..16 each settle
  // one bit of sqrt(2^30 - a^2) and of cbrt(r * 2^32)
  logic        v_q   [0:RootSteps];
  logic [15:0] a_q   [0:RootSteps];
  logic [15:0] t_q   [0:RootSteps];
  logic [15:0] r_q   [0:RootSteps];
  logic [30:0] sn_q  [0:RootSteps];
  logic [15:0] sr_q  [0:RootSteps];
  logic [32:0] ssq_q [0:RootSteps];
  logic [15:0] cr_q  [0:RootSteps];
  logic [32:0] c2_q  [0:RootSteps];
  logic [49:0] c3_q  [0:RootSteps];

  logic [15:0] a_mag;
  logic [31:0] a_sq;
  assign a_mag = req_i.polar_sample[15] ? 16'(-req_i.polar_sample) : req_i.polar_sample;
  assign a_sq  = 32'(a_mag) * 32'(a_mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q[0]   <= req_i.polar_sample;
    t_q[0]   <= req_i.azimuth_sample;
    r_q[0]   <= req_i.radial_sample;
    sn_q[0]  <= 31'(32'h4000_0000 - a_sq);
    sr_q[0]  <= '0;
    ssq_q[0] <= '0;
    cr_q[0]  <= '0;
    c2_q[0]  <= '0;
    c3_q[0]  <= '0;
  end

  for (genvar j = 0; j < RootSteps; j++) begin : g_root
    localparam int K = RootSteps - 1 - j;
    logic [32:0] s_cand;
    logic [32:0] c2_cand;
    logic [49:0] c3_cand;
    logic        s_take, c_take;

    assign s_cand  = ssq_q[j] + (33'(sr_q[j]) << (K + 1)) + (33'(1) << (2 * K));
    assign c2_cand = c2_q[j] + (33'(cr_q[j]) << (K + 1)) + (33'(1) << (2 * K));
    // (c + b)^3 = c^3 + 3 c^2 b + 3 c b^2 + b^3
    assign c3_cand = c3_q[j] + (50'(c2_q[j]) << (K + 1)) + (50'(c2_q[j]) << K)
                   + (50'(cr_q[j]) << (2 * K + 1)) + (50'(cr_q[j]) << (2 * K))
                   + (50'(1) << (3 * K));
    assign s_take  = s_cand <= 33'(sn_q[j]);
    assign c_take  = c3_cand <= {2'b00, r_q[j], 32'b0};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      a_q[j+1]   <= a_q[j];
      t_q[j+1]   <= t_q[j];
      r_q[j+1]   <= r_q[j];
      sn_q[j+1]  <= sn_q[j];
      sr_q[j+1]  <= s_take ? (sr_q[j] | (16'(1) << K)) : sr_q[j];
      ssq_q[j+1] <= s_take ? s_cand : ssq_q[j];
      cr_q[j+1]  <= c_take ? (cr_q[j] | (16'(1) << K)) : cr_q[j];
      c2_q[j+1]  <= c_take ? c2_cand : c2_q[j];
      c3_q[j+1]  <= c_take ? c3_cand : c3_q[j];
    end
  end

  // one horner step: k - floor(x2 * p / 2^30)
  function automatic logic [30:0] horner(input logic [30:0] k, input logic [30:0] x2,
                                         input logic [30:0] p);
    logic [61:0] prod;
    prod = 62'(x2) * 62'(p);
    return k - 31'(prod >> 30);
  endfunction

  // sine and scaling stages t1..t10
  logic [9:1]  vs_q;
  logic [15:0] a1_q, a2_q, a3_q, a4_q, a5_q, a6_q, a7_q;
  logic [15:0] sp1_q, sp2_q, sp3_q, sp4_q, sp5_q, sp6_q, sp7_q;
  logic [1:0]  q1_q, q2_q, q3_q, q4_q, q5_q, q6_q;
  logic [30:0] rad1_q, rad2_q, rad3_q, rad4_q, rad5_q, rad6_q, rad7_q, rad8_q;
  logic [14:0] us1_q, us2_q, us3_q, us4_q, us5_q;
  logic [14:0] uc1_q, uc2_q, uc3_q, uc4_q, uc5_q;
  logic [30:0] xs_q, xc_q;     // x^2 terms, q2.30
  logic [30:0] ps_q, pc_q;     // horner accumulators
  logic [31:0] ys_q, yc_q;     // sine before rounding, q2.30
  logic [15:0] ctm_q, stm_q;   // azimuth cos/sin magnitudes, q1.15
  logic        ctn_q, stn_q;
  logic [30:0] mx_q, my_q, mz_q;
  logic        nx_q, ny_q, nz_q;
  logic [31:0] ox_q, oy_q, oz_q;
  logic        onx_q, ony_q, onz_q;

  logic [14:0] f_in, fc_in;
  logic [46:0] rad_prod;
  assign f_in     = {1'b0, t_q[RootSteps][13:0]};
  assign fc_in    = 15'd16384 - f_in;
  assign rad_prod = 47'(radius_q) * 47'(cr_q[RootSteps]);

  logic [16:0] ysr, ycr;
  logic [15:0] sf, cf;
  assign ysr = 17'((ys_q + 32'd16384) >> 15);
  assign ycr = 17'((yc_q + 32'd16384) >> 15);
  assign sf  = (ysr > 17'd32768) ? 16'd32768 : ysr[15:0];
  assign cf  = (ycr > 17'd32768) ? 16'd32768 : ycr[15:0];

  logic [15:0] az_mag;
  assign az_mag = a7_q[15] ? 16'(-a7_q) : a7_q;

  function automatic logic [31:0] scale(input logic [30:0] rad, input logic [30:0] mag);
    logic [62:0] prod;
    prod = 63'(rad) * 63'(mag) + (63'(1) << 29);
    return 32'(prod >> 30);
  endfunction

  function automatic logic signed [CoordBits-1:0] place(
      input logic signed [CoordBits-1:0] c, input logic [31:0] mag, input logic neg);
    logic signed [CoordBits+1:0] s;
    s = $signed(34'(c)) + (neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag}));
    if (s > $signed({3'b000, {(CoordBits-1){1'b1}}})) begin
      return {1'b0, {(CoordBits-1){1'b1}}};
    end else if (s < -$signed({3'b001, {(CoordBits-1){1'b0}}})) begin
      return {1'b1, {(CoordBits-1){1'b0}}};
    end
    return s[CoordBits-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q   <= '0;
      done_o <= 1'b0;
    end else begin
      vs_q   <= {vs_q[8:1], v_q[RootSteps]};
      done_o <= vs_q[9];
    end
  end

  always_ff @(posedge clk_i) begin
    // t1: x^2 = 4 u^2 in q2.30, radius times cube root
    a1_q   <= a_q[RootSteps];
    sp1_q  <= sr_q[RootSteps];
    q1_q   <= t_q[RootSteps][15:14];
    rad1_q <= 31'(rad_prod >> 16);
    us1_q  <= f_in;
    uc1_q  <= fc_in;
    xs_q   <= 31'({(30'(f_in) * 30'(f_in)), 2'b00});
    xc_q   <= 31'({(30'(fc_in) * 30'(fc_in)), 2'b00});
    // t2..t5: horner steps, x^2 is carried in its own register per stage
    {a2_q, sp2_q, q2_q, rad2_q, us2_q, uc2_q} <= {a1_q, sp1_q, q1_q, rad1_q, us1_q, uc1_q};
    {a3_q, sp3_q, q3_q, rad3_q, us3_q, uc3_q} <= {a2_q, sp2_q, q2_q, rad2_q, us2_q, uc2_q};
    {a4_q, sp4_q, q4_q, rad4_q, us4_q, uc4_q} <= {a3_q, sp3_q, q3_q, rad3_q, us3_q, uc3_q};
    {a5_q, sp5_q, q5_q, rad5_q, us5_q, uc5_q} <= {a4_q, sp4_q, q4_q, rad4_q, us4_q, uc4_q};
    // t6: y = x * p1 / 2^30 = u * p1 / 2^14
    a6_q   <= a5_q;
    sp6_q  <= sp5_q;
    q6_q   <= q5_q;
    rad6_q <= rad5_q;
    ys_q   <= 32'((46'(us5_q) * 46'(ps_q)) >> 14);
    yc_q   <= 32'((46'(uc5_q) * 46'(pc_q)) >> 14);
    // t7: round to q1.15 and fold the quadrant
    a7_q   <= a6_q;
    sp7_q  <= sp6_q;
    rad7_q <= rad6_q;
    case (q6_q)
      2'd0:    begin stm_q <= sf; stn_q <= 1'b0; ctm_q <= cf; ctn_q <= 1'b0; end
      2'd1:    begin stm_q <= cf; stn_q <= 1'b0; ctm_q <= sf; ctn_q <= 1'b1; end
      2'd2:    begin stm_q <= sf; stn_q <= 1'b1; ctm_q <= cf; ctn_q <= 1'b1; end
      default: begin stm_q <= cf; stn_q <= 1'b1; ctm_q <= sf; ctn_q <= 1'b0; end
    endcase
    // t8: direction magnitudes, q2.30
    rad8_q <= rad7_q;
    mx_q   <= 31'(32'(sp7_q) * 32'(ctm_q));
    nx_q   <= ctn_q;
    my_q   <= 31'(32'(sp7_q) * 32'(stm_q));
    ny_q   <= stn_q;
    mz_q   <= {az_mag, 15'b0};
    nz_q   <= a7_q[15];
    // t9: offsets, rounded half away from zero
    ox_q   <= scale(rad8_q, mx_q);
    oy_q   <= scale(rad8_q, my_q);
    oz_q   <= scale(rad8_q, mz_q);
    onx_q  <= nx_q;
    ony_q  <= ny_q;
    onz_q  <= nz_q;
    // t10: add the center with saturation
    res_o.point_x <= place(center_x_q, ox_q, onx_q);
    res_o.point_y <= place(center_y_q, oy_q, ony_q);
    res_o.point_z <= place(center_z_q, oz_q, onz_q);
  end

  logic [30:0] ps2_q, pc2_q, ps3_q, pc3_q, ps4_q, pc4_q;
  logic [30:0] ps_n, pc_n;
  logic [30:0] xs2_q, xc2_q, xs3_q, xc3_q, xs4_q, xc4_q;

  always_ff @(posedge clk_i) begin
    // pipelined horner accumulators for both quarter sines, one term per stage
    ps_q <= ps_n;
    pc_q <= pc_n;
  end

  always_ff @(posedge clk_i) begin
    // t2: p7, starting from k9
    ps2_q <= horner(K7, xs_q, K9);
    pc2_q <= horner(K7, xc_q, K9);
    xs2_q <= xs_q;
    xc2_q <= xc_q;
    // t3: p5
    ps3_q <= horner(K5, xs2_q, ps2_q);
    pc3_q <= horner(K5, xc2_q, pc2_q);
    xs3_q <= xs2_q;
    xc3_q <= xc2_q;
    // t4: p3
    ps4_q <= horner(K3, xs3_q, ps3_q);
    pc4_q <= horner(K3, xc3_q, pc3_q);
    xs4_q <= xs3_q;
    xc4_q <= xc3_q;
  end

  // t5: p1 lands in ps_q / pc_q
  assign ps_n = horner(K1, xs4_q, ps4_q);
  assign pc_n = horner(K1, xc4_q, pc4_q);

`ifndef SYNTHESIS
  // every taken request yields a strobe on time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Latency done_o)
    else $error("request did not produce a point on time");

  // a strobe always traces back to a taken request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("point without a request");

  // zero x and z offsets place the point on the center in x and z
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vs_q[9] && ox_q == '0 && oz_q == '0 |=>
      res_o.point_x == center_x_q && res_o.point_z == center_z_q)
    else $error("zero offset moved the point off the center");
`endif

endmodule
